/* src/tca_pkg.sv */
// Package for the triangle classifier and area block.
// Holds the kind codes and the fixed widths of the result fields; no dependencies.
package tca_pkg;

	localparam int KIND_W    = 3;
	localparam int PERIM_W   = 18;
	localparam int AREA_W    = 31;
	localparam int QUEUE_DEPTH = 8;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EQUI      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RIGHT_ISO = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ISO       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RIGHT     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SCALENE   = 3'd5;

endpackage

/* src/tca_front.sv */
// Front end: triangle test, kind, perimeter and Heron factor products.
// Three stages that never stall; depends on tca_pkg.
module tca_front import tca_pkg::*; #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [W-1:0]          side_a,
	input  logic [W-1:0]          side_b,
	input  logic [W-1:0]          side_c,
	output logic                  out_valid,
	output logic [KIND_W-1:0]     out_kind,
	output logic [W+1:0]          out_perim,
	output logic [3*W+3:0]        out_plo,
	output logic [3*W+3:0]        out_phi,
	output logic [1:0]            inflight
);
	localparam int F1_W = 2*W + 3;
	localparam int F2_W = 2*W + 2;
	localparam int H    = W + 1;
	localparam int SQ_W = 2*W;
	localparam int PP_W = 3*W + 4;

	logic [W:0] ab, ac, bc, fa, fb, fc;
	logic       tri_ok;

	assign ab = {1'b0, side_a} + {1'b0, side_b};
	assign ac = {1'b0, side_a} + {1'b0, side_c};
	assign bc = {1'b0, side_b} + {1'b0, side_c};
	assign tri_ok = (ab > {1'b0, side_c}) && (ac > {1'b0, side_b}) && (bc > {1'b0, side_a});
	// Differences are only meaningful for a real triangle; zero them otherwise.
	assign fa = tri_ok ? bc - {1'b0, side_a} : '0;
	assign fb = tri_ok ? ac - {1'b0, side_b} : '0;
	assign fc = tri_ok ? ab - {1'b0, side_c} : '0;

	logic v_s1, v_s2, v_s3;
	logic tri_s1, eab_s1, eac_s1, ebc_s1;
	logic [2*W-1:0] sqa_s1, sqb_s1, sqc_s1;
	logic [W+1:0]   perim_s1, perim_s2, perim_s3;
	logic [W:0]     fa_s1, fb_s1, fc_s1;
	logic [KIND_W-1:0] kind_s2, kind_s3;
	logic [F1_W-1:0] f1_s2;
	logic [F2_W-1:0] f2_s2;
	logic [3*W+3:0]  plo_s3, phi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tri_s1   <= tri_ok;
		eab_s1   <= side_a == side_b;
		eac_s1   <= side_a == side_c;
		ebc_s1   <= side_b == side_c;
		sqa_s1   <= SQ_W'(side_a) * SQ_W'(side_a);
		sqb_s1   <= SQ_W'(side_b) * SQ_W'(side_b);
		sqc_s1   <= SQ_W'(side_c) * SQ_W'(side_c);
		perim_s1 <= tri_ok ? {1'b0, ab} + {2'b00, side_c} : '0;
		fa_s1    <= fa;
		fb_s1    <= fb;
		fc_s1    <= fc;
	end

	logic [2*W:0] sa2, sb2, sc2;
	logic         iso, right;
	logic [KIND_W-1:0] kind_c;

	assign sa2 = {1'b0, sqa_s1};
	assign sb2 = {1'b0, sqb_s1};
	assign sc2 = {1'b0, sqc_s1};
	assign iso = eab_s1 || eac_s1 || ebc_s1;
	assign right = (sa2 == sb2 + sc2) || (sb2 == sa2 + sc2) || (sc2 == sa2 + sb2);

	always_comb begin
		if (!tri_s1)
			kind_c = KIND_NONE;
		else if (eab_s1 && ebc_s1)
			kind_c = KIND_EQUI;
		else if (iso && right)
			kind_c = KIND_RIGHT_ISO;
		else if (iso)
			kind_c = KIND_ISO;
		else if (right)
			kind_c = KIND_RIGHT;
		else
			kind_c = KIND_SCALENE;
	end

	always_ff @(posedge clk) begin
		kind_s2  <= kind_c;
		perim_s2 <= perim_s1;
		f1_s2    <= F1_W'(perim_s1) * F1_W'(fa_s1);
		f2_s2    <= F2_W'(fb_s1) * F2_W'(fc_s1);
	end

	// The wide product is split into two partial products over the low and high halves of f2.
	always_ff @(posedge clk) begin
		kind_s3  <= kind_s2;
		perim_s3 <= perim_s2;
		plo_s3   <= PP_W'(f1_s2) * PP_W'(f2_s2[H-1:0]);
		phi_s3   <= PP_W'(f1_s2) * PP_W'(f2_s2[F2_W-1:H]);
	end

	assign out_valid = v_s3;
	assign out_kind  = kind_s3;
	assign out_perim = perim_s3;
	assign out_plo   = plo_s3;
	assign out_phi   = phi_s3;
	assign inflight  = 2'({1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3});

endmodule

/* src/tca_queue.sv */
// Small queue between the front and back ends.
// Register file with read and write pointers; depends on tca_pkg.
module tca_queue import tca_pkg::*; #(
	parameter int EW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [EW-1:0]     wr_data,
	input  logic              rd,
	output logic [EW-1:0]     rd_data,
	output logic              nonempty,
	output logic [QCNT_W-1:0] count
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [EW-1:0]     mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	assign rd_data  = mem_q[rp_q];
	assign nonempty = cnt_q != '0;
	assign count    = cnt_q;

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) cnt_q <= QCNT_W'(QUEUE_DEPTH);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue count beyond depth");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) rd |-> cnt_q != '0;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("read from empty queue");

	property p_no_overfill;
		@(posedge clk) disable iff (!arst_n) (wr && !rd) |-> cnt_q < QCNT_W'(QUEUE_DEPTH);
	endproperty
	a_no_overfill: assert property (p_no_overfill) else $error("write into full queue");

endmodule

/* src/tca_back.sv */
// Back end: joins the partial products and takes the square root one bit per stage.
// Holds the output register; depends on tca_pkg.
module tca_back import tca_pkg::*; #(
	parameter int W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [KIND_W-1:0]  in_kind,
	input  logic [W+1:0]       in_perim,
	input  logic [3*W+3:0]     in_plo,
	input  logic [3*W+3:0]     in_phi,
	output logic               in_take,
	output logic               out_valid,
	input  logic               out_pop,
	output logic [KIND_W-1:0]  out_kind,
	output logic [PERIM_W-1:0] out_perim,
	output logic [AREA_W-1:0]  out_area
);
	localparam int RB = 2*W + 3;
	localparam int NB = 2*RB;
	localparam int H  = W + 1;

	logic [NB-1:0]     rad_q   [RB+1];
	logic [RB+2:0]     rem_q   [RB+1];
	logic [RB-1:0]     root_q  [RB+1];
	logic [KIND_W-1:0] kind_q  [RB+1];
	logic [W+1:0]      perim_q [RB+1];
	logic [RB:0]       v_q;
	logic              en;

	// The whole chain moves together; it holds only while a result waits unclaimed.
	assign en      = !v_q[RB] || out_pop;
	assign in_take = en && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[RB-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0]   <= NB'(in_plo) + (NB'(in_phi) << H);
			rem_q[0]   <= '0;
			root_q[0]  <= '0;
			kind_q[0]  <= in_kind;
			perim_q[0] <= in_perim;
		end
	end

	for (genvar k = 0; k < RB; k++) begin : g_root
		logic [RB+2:0] cur, trial;
		logic          ge;
		assign cur   = {rem_q[k][RB:0], rad_q[k][NB-1:NB-2]};
		assign trial = {1'b0, root_q[k], 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k+1]   <= rad_q[k] << 2;
				rem_q[k+1]   <= ge ? cur - trial : cur;
				root_q[k+1]  <= {root_q[k][RB-2:0], ge};
				kind_q[k+1]  <= kind_q[k];
				perim_q[k+1] <= perim_q[k];
			end
		end
	end

	logic [RB+AREA_W-1:0]   area_ext;
	logic [W+1+PERIM_W:0]   perim_ext;

	assign area_ext  = {{AREA_W{1'b0}}, root_q[RB]} >> 2;
	assign perim_ext = {{PERIM_W{1'b0}}, perim_q[RB]};

	assign out_valid = v_q[RB];
	assign out_kind  = kind_q[RB];
	assign out_area  = area_ext[AREA_W-1:0];
	assign out_perim = perim_ext[PERIM_W-1:0];

endmodule

/* src/triangle_classify_area.sv */
// Top level of the triangle classifier with perimeter and Heron area.
// Instantiates tca_front, tca_queue and tca_back; depends on tca_pkg.
//
// Usage: the block looks like a queue on both sides. An input transfer
// happens at a rising edge with push high and full low and carries three
// unsigned side lengths. A result transfer happens at a rising edge with
// pop high and empty low; the oldest result sits on kind, perimeter and
// area while empty is low.
// The front end runs three stages (triangle test and squares, kind and
// factor products, partial products of the Heron product) and never
// stalls. It writes into an eight-entry queue. The back end adds the
// partial products and takes the square root one bit per stage, one stage
// per root bit. One item is taken every cycle while full is low.
// The back chain holds as a whole while a result waits unclaimed; the
// queue then fills, and full rises once the queue and the front stages
// together hold eight items. full is worked out from the queue count
// and the front valid bits, so it never depends on pop.
// Reset clears all valid bits and the queue pointers; empty goes high and
// full goes low at once; items in flight are dropped and no result is made up.
module triangle_classify_area import tca_pkg::*; #(
	parameter int SIDE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [SIDE_WIDTH-1:0] side_a,
	input  logic [SIDE_WIDTH-1:0] side_b,
	input  logic [SIDE_WIDTH-1:0] side_c,
	output logic                  empty,
	input  logic                  pop,
	output logic [KIND_W-1:0]     kind,
	output logic [PERIM_W-1:0]    perimeter,
	output logic [AREA_W-1:0]     area
);
	localparam int W  = SIDE_WIDTH;
	localparam int PP = 3*W + 4;
	localparam int EW = KIND_W + (W + 2) + 2*PP;

	logic              accept;
	logic              f_valid;
	logic [KIND_W-1:0] f_kind;
	logic [W+1:0]      f_perim;
	logic [PP-1:0]     f_plo, f_phi;
	logic [1:0]        inflight;

	logic [EW-1:0]     q_head;
	logic              q_nonempty, q_take;
	logic [QCNT_W-1:0] q_count;
	logic              out_valid;

	// Credit check: the queue always has room for every item still in the front end.
	assign full   = (QCNT_W'(q_count) + QCNT_W'(inflight)) >= QCNT_W'(QUEUE_DEPTH);
	assign accept = push && !full;

	tca_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.side_a    (side_a),
		.side_b    (side_b),
		.side_c    (side_c),
		.out_valid (f_valid),
		.out_kind  (f_kind),
		.out_perim (f_perim),
		.out_plo   (f_plo),
		.out_phi   (f_phi),
		.inflight  (inflight)
	);

	tca_queue #(.EW(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (f_valid),
		.wr_data  ({f_kind, f_perim, f_plo, f_phi}),
		.rd       (q_take),
		.rd_data  (q_head),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	tca_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_nonempty),
		.in_kind   (q_head[EW-1 -: KIND_W]),
		.in_perim  (q_head[2*PP+W+1 -: W+2]),
		.in_plo    (q_head[2*PP-1 -: PP]),
		.in_phi    (q_head[PP-1:0]),
		.in_take   (q_take),
		.out_valid (out_valid),
		.out_pop   (pop),
		.out_kind  (kind),
		.out_perim (perimeter),
		.out_area  (area)
	);

	assign empty = !out_valid;

	property p_none_is_zero;
		@(posedge clk) disable iff (!arst_n)
			(!empty && kind == KIND_NONE) |-> (perimeter == '0 && area == '0);
	endproperty
	a_none_is_zero: assert property (p_none_is_zero)
		else $error("non-triangle result with nonzero perimeter or area");

	property p_credit;
		@(posedge clk) disable iff (!arst_n)
			(QCNT_W'(q_count) + QCNT_W'(inflight)) <= QCNT_W'(QUEUE_DEPTH);
	endproperty
	a_credit: assert property (p_credit) else $error("front end overcommitted the queue");

	property p_hold_result;
		@(posedge clk) disable iff (!arst_n)
			(!empty && !pop) |=> (!empty && $stable(kind) && $stable(area));
	endproperty
	a_hold_result: assert property (p_hold_result) else $error("waiting result changed");

endmodule

/* test/triangle_classify_area_tb.sv */
// Testbench for triangle_classify_area: directed and random side triples.
// Checks kind, perimeter and Heron area against an in-bench predictor; depends on tca_pkg.
`timescale 1ns / 1ps

module triangle_classify_area_tb import tca_pkg::*;;

	localparam int SW = 16;

	typedef struct packed {
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		logic [SW-1:0] c;
	} sides_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PERIM_W-1:0] perim;
		logic [AREA_W-1:0]  area;
	} tri_result_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [SW-1:0] side_a;
	logic [SW-1:0] side_b;
	logic [SW-1:0] side_c;
	logic empty;
	logic pop;
	logic [KIND_W-1:0] kind;
	logic [PERIM_W-1:0] perimeter;
	logic [AREA_W-1:0] area;

	sides_t      pending_sides[$];
	tri_result_t expected_shapes[$];
	int          mismatches = 0;
	int          push_idle = 0;
	int          pop_idle = 0;
	bit          calm = 0;
	bit          stim_done = 0;

	triangle_classify_area #(.SIDE_WIDTH(SW)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.side_a(side_a), .side_b(side_b), .side_c(side_c),
		.empty(empty), .pop(pop), .kind(kind), .perimeter(perimeter), .area(area)
	);

	// Integer square root, one bit at a time from the top.
	function automatic logic [63:0] isqrt(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if ({64'd0, cand} * {64'd0, cand} <= n)
				r = cand;
		end
		return r;
	endfunction

	// Classify the triangle and work out perimeter and floored Heron area.
	function automatic tri_result_t classify_triangle(sides_t s);
		tri_result_t res;
		logic [63:0] a, b, c, a2, b2, c2, p, f1, f2;
		logic iso, right;
		a = 64'(s.a);
		b = 64'(s.b);
		c = 64'(s.c);
		res = '0;
		if (!(a + b > c && a + c > b && b + c > a)) begin
			res.kind = KIND_NONE;
			return res;
		end
		a2 = a * a;
		b2 = b * b;
		c2 = c * c;
		iso = (a == b) || (a == c) || (b == c);
		right = (a2 == b2 + c2) || (b2 == a2 + c2) || (c2 == a2 + b2);
		if (a == b && b == c)
			res.kind = KIND_EQUI;
		else if (iso && right)
			res.kind = KIND_RIGHT_ISO;
		else if (iso)
			res.kind = KIND_ISO;
		else if (right)
			res.kind = KIND_RIGHT;
		else
			res.kind = KIND_SCALENE;
		p = a + b + c;
		f1 = p * (b + c - a);
		f2 = (a + c - b) * (a + b - c);
		res.perim = p[PERIM_W-1:0];
		res.area = AREA_W'(isqrt({64'd0, f1} * {64'd0, f2}) >> 2);
		return res;
	endfunction

	task automatic queue_sides(input logic [SW-1:0] a, b, c);
		pending_sides.push_back('{a: a, b: b, c: c});
	endtask

	// Draws a random triple; most are proper triangles of mixed sizes.
	task automatic queue_random_triangle();
		logic [SW-1:0] a, b, c, lo;
		int sel;
		sel = $urandom_range(0, 9);
		a = SW'($urandom);
		b = SW'($urandom);
		c = SW'($urandom);
		case (sel)
			0: begin
				// Raw noise across the full range.
			end
			1: begin
				b = a;
				c = SW'($urandom_range(1, 32767));
				if (a < 2) a = 2;
				b = a;
			end
			2: begin
				// Right triangle scaled from a Pythagorean triple.
				int k;
				k = $urandom_range(1, 2000);
				case ($urandom_range(0, 2))
					0: begin a = SW'(3 * k); b = SW'(4 * k); c = SW'(5 * k); end
					1: begin a = SW'(5 * k); b = SW'(12 * k); c = SW'(13 * k); end
					default: begin a = SW'(8 * (k % 1000 + 1)); b = SW'(15 * (k % 1000 + 1));
						c = SW'(17 * (k % 1000 + 1)); end
				endcase
			end
			3: begin
				// Degenerate: one side is the sum of the other two.
				a = SW'($urandom_range(0, 32767));
				b = SW'($urandom_range(0, 32767));
				c = a + b;
			end
			4: begin
				a = SW'($urandom_range(1, 255));
				b = SW'($urandom_range(1, 255));
				c = SW'($urandom_range(1, 255));
			end
			default: begin
				// Force c inside the open interval |a-b| < c < a+b when the smaller of a and b exceeds 1.
				lo = (a > b) ? a - b : b - a;
				if (32'(a) + 32'(b) - 32'(lo) > 2 && 32'(a) + 32'(b) - 1 <= 65535)
					c = SW'($urandom_range(32'(a) + 32'(b) - 1, 32'(lo) + 1));
				else if (32'(a) + 32'(b) > 65535)
					c = SW'($urandom_range(65535, 32'(lo) + 1));
			end
		endcase
		case ($urandom_range(0, 2))
			0: queue_sides(a, b, c);
			1: queue_sides(c, a, b);
			default: queue_sides(b, c, a);
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		// Directed part: zero sides, extremes, every kind but right isosceles, and degenerate shapes.
		queue_sides(0, 0, 0);
		queue_sides(0, 100, 100);
		queue_sides(100, 0, 100);
		queue_sides(100, 100, 0);
		queue_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_sides(1, 1, 1);
		queue_sides(16'hFFFF, 16'hFFFF, 1);
		queue_sides(16'hFFFF, 16'hFFFE, 16'hFFFD);
		queue_sides(300, 400, 500);
		queue_sides(500, 300, 400);
		queue_sides(13107, 17476, 21845);
		queue_sides(100, 100, 150);
		queue_sides(1, 2, 3);
		queue_sides(32768, 32767, 16'hFFFF);
		queue_sides(16'hAAAA, 16'h5555, 16'hFFFF);
		queue_sides(16'h5555, 16'hAAAA, 16'h8000);
		queue_sides(5, 7, 9);
		queue_sides(2, 3, 6);
		queue_sides(7, 7, 14);
		queue_sides(16'h8000, 16'h8000, 16'h8000);
		for (int i = 0; i < 1130; i++)
			queue_random_triangle();
		wait (pending_sides.size() == 0 && !push);
		stim_done = 1'b1;
	end

	// Idling stops once fewer than about a hundred items are left.
	always @(posedge clk)
		if (pending_sides.size() < 100)
			calm <= 1'b1;

	// Driver: presents the head of the pending queue, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			side_a <= '0;
			side_b <= '0;
			side_c <= '0;
		end else begin
			if (push && !full)
				void'(pending_sides.pop_front());
			if (push_idle > 0) begin
				push_idle <= push_idle - 1;
				push <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0 && !(push && full)) begin
				push_idle <= $urandom_range(0, 7);
				push <= 1'b0;
			end else begin
				// Keep the same item up while it waits on full.
				if (push && full) begin
					push <= 1'b1;
				end else if (pending_sides.size() > 0) begin
					push <= 1'b1;
					side_a <= pending_sides[0].a;
					side_b <= pending_sides[0].b;
					side_c <= pending_sides[0].c;
					expected_shapes.push_back(classify_triangle(pending_sides[0]));
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		tri_result_t exp_r;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_shapes.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result kind=%0d perim=%0d area=%0d",
							kind, perimeter, area);
				end else begin
					exp_r = expected_shapes.pop_front();
					if (exp_r.kind !== kind || exp_r.perim !== perimeter ||
						exp_r.area !== area) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: exp kind=%0d perim=%0d area=%0d, %s%0d %s%0d %s%0d",
								exp_r.kind, exp_r.perim, exp_r.area,
								"got kind=", kind, "perim=", perimeter, "area=", area);
					end
				end
			end
			if (pop_idle > 0) begin
				pop_idle <= pop_idle - 1;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop_idle <= $urandom_range(0, 7);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Expectations are queued when an item is first presented, so an item
	// still held on the ports is already counted; the wait below covers it.
	initial begin
		wait (stim_done);
		wait (expected_shapes.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_shapes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
